/* sv/rtss_pkg.sv */
// Shared types and constants for the relay time switch scheduler.
// No dependencies; used by the channel evaluator, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package rtss_pkg;

  localparam int MinutesPerHour = 60;
  localparam int MinutesPerDay  = 24 * 60;
  localparam int MinW           = 11;   // minute-of-day, covers out-of-range hours too
  localparam int DistW          = 13;   // signed distance between two minute-of-day values
  localparam int JobW           = 13;
  localparam int SlotsMax       = 4;    // register slots per channel
  localparam int NumChan        = 2;
  localparam int CfgIdxW        = 3;

  typedef enum logic [1:0] {
    REQ_TICK     = 2'd0,
    REQ_MANUAL   = 2'd1,
    REQ_POLARITY = 2'd2,
    REQ_RSVD     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    CH_NONE = 2'd0,
    CH_ONE  = 2'd1,
    CH_TWO  = 2'd2,
    CH_BAD  = 2'd3
  } chan_sel_e;

  typedef struct packed {
    logic       enabled;
    logic       action;
    logic [4:0] hour;
    logic [5:0] minute;
  } job_t;

  function automatic logic [MinW-1:0] day_minutes(logic [4:0] hour, logic [5:0] minute);
    return MinW'(hour) * MinW'(MinutesPerHour) + MinW'(minute);
  endfunction

endpackage

/* sv/rtss_req_if.sv */
// Request channel of the relay time switch scheduler: valid/ready plus one request beat.
// No dependencies.
`timescale 1ns / 1ps

interface rtss_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       time_valid;
  logic [4:0] hour_now;
  logic [5:0] minute_now;
  logic [1:0] channel_sel;
  logic       relay_on;
  logic       polarity_low;

  modport source (
    output valid, req_type, time_valid, hour_now, minute_now, channel_sel, relay_on,
           polarity_low,
    input  ready
  );
  modport sink (
    input  valid, req_type, time_valid, hour_now, minute_now, channel_sel, relay_on,
           polarity_low,
    output ready
  );
endinterface

/* sv/rtss_rsp_if.sv */
// Result channel of the relay time switch scheduler: valid/ready plus one status beat.
// No dependencies.
`timescale 1ns / 1ps

interface rtss_rsp_if;
  logic valid;
  logic ready;
  logic relay1_state;
  logic relay2_state;
  logic relay1_level;
  logic relay2_level;
  logic is_active_low;
  logic cmd_error;

  modport source (
    output valid, relay1_state, relay2_state, relay1_level, relay2_level, is_active_low,
           cmd_error,
    input  ready
  );
  modport sink (
    input  valid, relay1_state, relay2_state, relay1_level, relay2_level, is_active_low,
           cmd_error,
    output ready
  );
endinterface

/* sv/rtss_chan_eval.sv */
// Per-channel job evaluation: catch-up (most recently due job) or exact-minute firing.
// Depends on rtss_pkg.
`timescale 1ns / 1ps

module rtss_chan_eval
  import rtss_pkg::*;
#(
  parameter int JOBS_PER_CHANNEL = 4
) (
  input  job_t [JOBS_PER_CHANNEL-1:0] jobs_i,
  input  logic [MinW-1:0]             now_i,
  input  logic                        relay_i,
  output logic                        catch_relay_o,
  output logic                        fire_relay_o
);

  // catch-up: smallest backward distance below a day, lowest slot wins ties
  always_comb begin
    logic signed [DistW-1:0] best;
    logic signed [DistW-1:0] gap;
    best          = DistW'(MinutesPerDay);
    catch_relay_o = relay_i;
    for (int i = 0; i < JOBS_PER_CHANNEL; i++) begin
      gap = $signed({2'b00, now_i})
          - $signed({2'b00, day_minutes(jobs_i[i].hour, jobs_i[i].minute)});
      if (gap < 0) begin
        gap = gap + DistW'(MinutesPerDay);
      end
      if (jobs_i[i].enabled && (gap < best)) begin
        best          = gap;
        catch_relay_o = jobs_i[i].action;
      end
    end
  end

  // exact match: later slot wins
  always_comb begin
    fire_relay_o = relay_i;
    for (int i = 0; i < JOBS_PER_CHANNEL; i++) begin
      if (jobs_i[i].enabled && (day_minutes(jobs_i[i].hour, jobs_i[i].minute) == now_i)) begin
        fire_relay_o = jobs_i[i].action;
      end
    end
  end

endmodule

/* sv/relay_time_switch_scheduler.sv */
// Top level of the two-channel daily relay time switch scheduler.
// Depends on rtss_pkg, rtss_req_if, rtss_rsp_if and rtss_chan_eval.
//
// Usage:
//   req_i  : request beats (time tick, manual relay command, polarity set).
//   rsp_o  : one status beat per request: logical relay states, pin levels,
//            polarity and the bad-channel flag of a manual command.
//   cfg_*  : job table writes, index 0..3 channel one, 4..7 channel two.
//            Write only while no request is in flight.
// Path: an accepted request is held in the request register, then evaluated
//   into the result register, which presents it as a result beat.
// Throughput: one beat per cycle when not stalled; the whole job evaluation
//   for both channels sits between the request and the result register.
// Reset: relays off, active-low polarity, clock not yet synced, job table
//   cleared. No beat is pending after reset.
// Stall: while the result is not taken the request register holds; one more
//   request is still taken into the empty request register, then ready drops.
`timescale 1ns / 1ps

module relay_time_switch_scheduler
  import rtss_pkg::*;
#(
  parameter int JOBS_PER_CHANNEL = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [JobW-1:0]    cfg_data_i,
  rtss_req_if.sink           req_i,
  rtss_rsp_if.source         rsp_o
);

  job_t [NumChan-1:0][JOBS_PER_CHANNEL-1:0] job_q;

  // request register
  logic       s1_valid_q, s1_valid_d;
  logic [1:0] s1_type_q;
  logic       s1_tvalid_q;
  logic [4:0] s1_hour_q;
  logic [5:0] s1_min_q;
  logic [1:0] s1_chan_q;
  logic       s1_on_q;
  logic       s1_pol_q;

  // scheduler state
  logic            relay1_q, relay1_d;
  logic            relay2_q, relay2_d;
  logic            pol_q, pol_d;
  logic            synced_q, synced_d;
  logic [MinW-1:0] last_min_q, last_min_d;
  logic            last_vld_q, last_vld_d;
  logic            err_d;

  // result register
  logic out_valid_q, out_valid_d;
  logic out_r1_q, out_r2_q, out_pol_q, out_err_q;

  logic            advance;
  logic            req_acc;
  logic [MinW-1:0] now;
  logic [NumChan-1:0] catch_rel, fire_rel, cur_rel;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !s1_valid_q || advance;
  assign req_acc     = req_i.valid && req_i.ready;
  assign now         = day_minutes(s1_hour_q, s1_min_q);
  assign cur_rel     = {relay2_q, relay1_q};

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    rtss_chan_eval #(
      .JOBS_PER_CHANNEL(JOBS_PER_CHANNEL)
    ) u_eval (
      .jobs_i       (job_q[c]),
      .now_i        (now),
      .relay_i      (cur_rel[c]),
      .catch_relay_o(catch_rel[c]),
      .fire_relay_o (fire_rel[c])
    );
  end

  always_comb begin
    relay1_d   = relay1_q;
    relay2_d   = relay2_q;
    pol_d      = pol_q;
    synced_d   = synced_q;
    last_min_d = last_min_q;
    last_vld_d = last_vld_q;
    err_d      = 1'b0;
    case (req_type_e'(s1_type_q))
      REQ_TICK: begin
        if (s1_tvalid_q) begin
          if (!synced_q) begin
            synced_d = 1'b1;
            relay1_d = catch_rel[0];
            relay2_d = catch_rel[1];
          end else if (!(last_vld_q && (last_min_q == now))) begin
            relay1_d   = fire_rel[0];
            relay2_d   = fire_rel[1];
            last_min_d = now;
            last_vld_d = 1'b1;
          end
        end
      end
      REQ_MANUAL: begin
        unique case (chan_sel_e'(s1_chan_q))
          CH_ONE:         relay1_d = s1_on_q;
          CH_TWO:         relay2_d = s1_on_q;
          CH_NONE, CH_BAD: err_d   = 1'b1;
          default:        err_d    = 1'b1;
        endcase
      end
      REQ_POLARITY: begin
        pol_d    = s1_pol_q;
        relay1_d = 1'b0;
        relay2_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (req_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_valid_q && advance) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      relay1_q    <= 1'b0;
      relay2_q    <= 1'b0;
      pol_q       <= 1'b1;
      synced_q    <= 1'b0;
      last_min_q  <= '0;
      last_vld_q  <= 1'b0;
      job_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_valid_q && advance) begin
        relay1_q   <= relay1_d;
        relay2_q   <= relay2_d;
        pol_q      <= pol_d;
        synced_q   <= synced_d;
        last_min_q <= last_min_d;
        last_vld_q <= last_vld_d;
      end
      for (int c = 0; c < NumChan; c++) begin
        for (int s = 0; s < JOBS_PER_CHANNEL; s++) begin
          if (cfg_we_i && (cfg_idx_i == CfgIdxW'(c * SlotsMax + s))) begin
            job_q[c][s] <= job_t'(cfg_data_i);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_type_q   <= req_i.req_type;
      s1_tvalid_q <= req_i.time_valid;
      s1_hour_q   <= req_i.hour_now;
      s1_min_q    <= req_i.minute_now;
      s1_chan_q   <= req_i.channel_sel;
      s1_on_q     <= req_i.relay_on;
      s1_pol_q    <= req_i.polarity_low;
    end
    if (s1_valid_q && advance) begin
      out_r1_q  <= relay1_d;
      out_r2_q  <= relay2_d;
      out_pol_q <= pol_d;
      out_err_q <= err_d;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.relay1_state  = out_r1_q;
  assign rsp_o.relay2_state  = out_r2_q;
  assign rsp_o.relay1_level  = out_r1_q ^ out_pol_q;
  assign rsp_o.relay2_level  = out_r2_q ^ out_pol_q;
  assign rsp_o.is_active_low = out_pol_q;
  assign rsp_o.cmd_error     = out_err_q;

endmodule

/* verif/rtss_checker.sv */
// Scoreboard for the relay time switch scheduler: mirrors the job table from the config port,
// predicts one status beat per request beat and compares it with the result channel.
// Depends on rtss_pkg, rtss_req_if and rtss_rsp_if.
`timescale 1ns / 1ps

module rtss_checker
  import rtss_pkg::*;
#(
  parameter int JOBS_PER_CHANNEL = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [JobW-1:0]    cfg_data_i,
  rtss_req_if                req_i,
  rtss_rsp_if                rsp_i,
  output int                 exp_count_o,
  output int                 got_count_o,
  output int                 fail_count_o
);

  typedef struct packed {
    logic relay1_state;
    logic relay2_state;
    logic relay1_level;
    logic relay2_level;
    logic is_active_low;
    logic cmd_error;
  } status_t;

  job_t            job_tbl [NumChan][SlotsMax];
  logic            relay_q [NumChan];
  logic            act_low_q;
  logic            synced_q;
  logic [MinW-1:0] last_min_q;
  logic            last_min_vld_q;
  status_t         status_q [$];
  int              n_exp;
  int              n_got;
  int              n_fail;

  function automatic int minute_of_day(logic [4:0] hour, logic [5:0] minute);
    return int'(hour) * MinutesPerHour + int'(minute);
  endfunction

  // most recently due enabled job; a distance can stay negative for out-of-range job times
  function automatic void catch_up_chan(int ch, int now);
    int best;
    int best_dist;
    int gap;
    best      = -1;
    best_dist = MinutesPerDay;
    for (int i = 0; i < JOBS_PER_CHANNEL && i < SlotsMax; i++) begin
      if (job_tbl[ch][i].enabled) begin
        gap = now - minute_of_day(job_tbl[ch][i].hour, job_tbl[ch][i].minute);
        if (gap < 0) gap += MinutesPerDay;
        if (gap < best_dist) begin
          best_dist = gap;
          best      = i;
        end
      end
    end
    if (best >= 0) relay_q[ch] = job_tbl[ch][best].action;
  endfunction

  function automatic void fire_chan(int ch, int now);
    for (int i = 0; i < JOBS_PER_CHANNEL && i < SlotsMax; i++) begin
      if (job_tbl[ch][i].enabled &&
          minute_of_day(job_tbl[ch][i].hour, job_tbl[ch][i].minute) == now)
        relay_q[ch] = job_tbl[ch][i].action;
    end
  endfunction

  function automatic status_t predict_status(req_type_e rt, logic tv, logic [4:0] hour,
                                             logic [5:0] minute, chan_sel_e ch, logic on,
                                             logic pol_low);
    status_t s;
    int      now;
    s   = '0;
    now = minute_of_day(hour, minute);
    case (rt)
      REQ_TICK: begin
        if (tv) begin
          if (!synced_q) begin
            synced_q = 1'b1;
            catch_up_chan(0, now);
            catch_up_chan(1, now);
          end else if (!(last_min_vld_q && last_min_q == MinW'(now))) begin
            fire_chan(0, now);
            fire_chan(1, now);
            last_min_q     = MinW'(now);
            last_min_vld_q = 1'b1;
          end
        end
      end
      REQ_MANUAL: begin
        case (ch)
          CH_ONE:  relay_q[0] = on;
          CH_TWO:  relay_q[1] = on;
          default: s.cmd_error = 1'b1;
        endcase
      end
      REQ_POLARITY: begin
        act_low_q  = pol_low;
        relay_q[0] = 1'b0;
        relay_q[1] = 1'b0;
      end
      default: ;
    endcase
    s.relay1_state  = relay_q[0];
    s.relay2_state  = relay_q[1];
    s.relay1_level  = relay_q[0] ^ act_low_q;
    s.relay2_level  = relay_q[1] ^ act_low_q;
    s.is_active_low = act_low_q;
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : check_blk
    status_t want;
    status_t seen;
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        relay_q[c] = 1'b0;
        for (int i = 0; i < SlotsMax; i++) job_tbl[c][i] = '0;
      end
      act_low_q      = 1'b1;
      synced_q       = 1'b0;
      last_min_q     = '0;
      last_min_vld_q = 1'b0;
      status_q.delete();
      n_exp          = 0;
      n_got          = 0;
      n_fail         = 0;
    end else begin
      if (cfg_we_i) job_tbl[cfg_idx_i[2]][cfg_idx_i[1:0]] = job_t'(cfg_data_i);
      if (rsp_i.valid && rsp_i.ready) begin
        n_got++;
        seen = {rsp_i.relay1_state, rsp_i.relay2_state, rsp_i.relay1_level, rsp_i.relay2_level,
                rsp_i.is_active_low, rsp_i.cmd_error};
        if (status_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected status beat %0d: %b", n_got, seen);
        end else begin
          want = status_q.pop_front();
          if (seen !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display({"beat %0d mismatch: exp st1=%b st2=%b pin1=%b pin2=%b low=%b err=%b,",
                        " got st1=%b st2=%b pin1=%b pin2=%b low=%b err=%b"}, n_got,
                       want.relay1_state, want.relay2_state, want.relay1_level,
                       want.relay2_level, want.is_active_low, want.cmd_error,
                       seen.relay1_state, seen.relay2_state, seen.relay1_level,
                       seen.relay2_level, seen.is_active_low, seen.cmd_error);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        n_exp++;
        status_q.push_back(predict_status(req_type_e'(req_i.req_type), req_i.time_valid,
                                          req_i.hour_now, req_i.minute_now,
                                          chan_sel_e'(req_i.channel_sel), req_i.relay_on,
                                          req_i.polarity_low));
      end
    end
    exp_count_o  <= n_exp;
    got_count_o  <= n_got;
    fail_count_o <= n_fail;
  end

endmodule

/* verif/tb_top.sv */
// Top of the relay time switch scheduler testbench: clock, reset, job table phases,
// directed and bursty random request beats, receiver stalls, watchdog and verdict.
// Depends on rtss_pkg, the two channel interfaces, the block and rtss_checker.
`timescale 1ns / 1ps

module tb_top;
  import rtss_pkg::*;

  localparam int ItemsPerPhase = 175;
  localparam int NumPhases     = 7;
  localparam int IdleLimit     = 3000;
  localparam int HoldCycles    = 300;
  localparam int HoldAfter     = 500;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [JobW-1:0]    cfg_data;
  int                 exp_count;
  int                 got_count;
  int                 fail_count;
  int                 idle_cycles;
  int                 n_tick;
  int                 n_manual;
  int                 n_pol;
  int                 n_rsvd;
  logic [JobW-1:0]    job_shadow [8];
  logic [4:0]         last_hour;
  logic [5:0]         last_minute;
  bit                 hold_done;

  rtss_req_if req_bus ();
  rtss_rsp_if rsp_bus ();

  relay_time_switch_scheduler #(.JOBS_PER_CHANNEL(4)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  rtss_checker #(.JOBS_PER_CHANNEL(4)) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .req_i        (req_bus),
    .rsp_i        (rsp_bus),
    .exp_count_o  (exp_count),
    .got_count_o  (got_count),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_req(req_type_e rt, logic tv, logic [4:0] hour, logic [5:0] minute,
                          chan_sel_e ch, logic on, logic pol_low);
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= rt;
    req_bus.time_valid   <= tv;
    req_bus.hour_now     <= hour;
    req_bus.minute_now   <= minute;
    req_bus.channel_sel  <= ch;
    req_bus.relay_on     <= on;
    req_bus.polarity_low <= pol_low;
    do @(posedge clk_i); while (!req_bus.ready);
    case (rt)
      REQ_TICK:     n_tick++;
      REQ_MANUAL:   n_manual++;
      REQ_POLARITY: n_pol++;
      default:      n_rsvd++;
    endcase
    if (rt == REQ_TICK) begin
      last_hour   = hour;
      last_minute = minute;
    end
  endtask

  task automatic idle_for(int cycles);
    req_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (exp_count != got_count) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_job(int idx, logic [JobW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgIdxW'(idx);
    cfg_data <= val;
    job_shadow[idx] = val;
    @(posedge clk_i);
  endtask

  function automatic logic [JobW-1:0] random_job(int idx);
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return {1'b0, 12'($urandom)};
    if (r < 35) return JobW'($urandom);
    if (r < 60 && (idx % 4) != 0)
      return {1'b1, 1'($urandom), job_shadow[idx-1][10:0]};
    return {1'b1, 1'($urandom), 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59))};
  endfunction

  task automatic load_table(int kind);
    logic [JobW-1:0] val;
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      case (kind)
        0:       val = '1;
        1:       val = '0;
        2:       val = {1'b1, 1'(i), 5'd12, 6'd30};
        default: val = random_job(i);
      endcase
      write_job(i, val);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_req();
    int         r;
    int         t;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       tv;
    r  = $urandom_range(0, 99);
    t  = $urandom_range(0, 99);
    tv = ($urandom_range(0, 9) != 0);
    if (t < 65) begin
      r = (r < 60) ? r : r;
      {hour, minute} = job_shadow[$urandom_range(0, 7)][10:0];
    end else if (t < 80) begin
      hour   = last_hour;
      minute = last_minute;
    end else if (t < 92) begin
      hour   = 5'($urandom_range(0, 23));
      minute = 6'($urandom_range(0, 59));
    end else begin
      hour   = 5'($urandom);
      minute = 6'($urandom);
    end
    if (r < 60)
      send_req(REQ_TICK, tv, hour, minute, chan_sel_e'(2'($urandom)), 1'($urandom),
               1'($urandom));
    else if (r < 80)
      send_req(REQ_MANUAL, 1'($urandom), hour, minute, chan_sel_e'(2'($urandom)),
               1'($urandom), 1'($urandom));
    else if (r < 92)
      send_req(REQ_POLARITY, 1'($urandom), hour, minute, chan_sel_e'(2'($urandom)),
               1'($urandom), 1'($urandom));
    else
      send_req(REQ_RSVD, 1'($urandom), hour, minute, chan_sel_e'(2'($urandom)),
               1'($urandom), 1'($urandom));
  endtask

  task automatic random_phase(int items);
    int left;
    int burst;
    left = items;
    while (left > 0) begin
      burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 30);
      for (int i = 0; i < burst && left > 0; i++) begin
        random_req();
        left--;
      end
      if ($urandom_range(0, 9) >= 3) idle_for($urandom_range(1, 12));
    end
  endtask

  // receiver: stall pattern changes per segment, one long hold to back up the block
  initial begin : rx_proc
    int seg;
    int mode;
    int k;
    rsp_bus.ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk_i);
    forever begin
      seg  = $urandom_range(20, 150);
      mode = $urandom_range(0, 2);
      k    = $urandom_range(2, 6);
      for (int c = 0; c < seg; c++) begin
        if (!hold_done && got_count >= HoldAfter) begin
          hold_done = 1'b1;
          rsp_bus.ready <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
        end
        case (mode)
          0:       rsp_bus.ready <= 1'b1;
          1:       rsp_bus.ready <= 1'($urandom);
          default: rsp_bus.ready <= ((c % k) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stim_proc
    rst_ni               <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= '0;
    cfg_data             <= '0;
    req_bus.valid        <= 1'b0;
    req_bus.req_type     <= REQ_TICK;
    req_bus.time_valid   <= 1'b0;
    req_bus.hour_now     <= '0;
    req_bus.minute_now   <= '0;
    req_bus.channel_sel  <= CH_NONE;
    req_bus.relay_on     <= 1'b0;
    req_bus.polarity_low <= 1'b0;
    n_tick      = 0;
    n_manual    = 0;
    n_pol       = 0;
    n_rsvd      = 0;
    last_hour   = '0;
    last_minute = '0;
    for (int i = 0; i < 8; i++) job_shadow[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // catch-up table: ch1 ties at 01:00 (lower slot wins), ch2 out-of-range slot wins
    write_job(0, {1'b1, 1'b1, 5'd1, 6'd0});
    write_job(1, {1'b1, 1'b0, 5'd1, 6'd0});
    write_job(2, {1'b1, 1'b0, 5'd3, 6'd0});
    write_job(3, {1'b0, 1'b0, 5'd2, 6'd0});
    write_job(4, {1'b1, 1'b1, 5'd31, 6'd63});
    write_job(5, {1'b1, 1'b0, 5'd1, 6'd0});
    write_job(6, {1'b1, 1'b0, 5'd2, 6'd0});
    write_job(7, {1'b0, 1'b1, 5'd0, 6'd0});
    cfg_we <= 1'b0;

    send_req(REQ_TICK,     1'b0, 5'd31, 6'd63, CH_BAD,  1'b1, 1'b1);
    send_req(REQ_MANUAL,   1'b0, 5'd0,  6'd0,  CH_NONE, 1'b1, 1'b0);
    send_req(REQ_MANUAL,   1'b1, 5'd31, 6'd63, CH_ONE,  1'b1, 1'b0);
    send_req(REQ_MANUAL,   1'b0, 5'd0,  6'd0,  CH_TWO,  1'b1, 1'b1);
    send_req(REQ_MANUAL,   1'b1, 5'd0,  6'd0,  CH_BAD,  1'b0, 1'b0);
    send_req(REQ_POLARITY, 1'b1, 5'd31, 6'd63, CH_BAD,  1'b1, 1'b0);
    send_req(REQ_MANUAL,   1'b0, 5'd0,  6'd0,  CH_ONE,  1'b1, 1'b0);
    send_req(REQ_RSVD,     1'b1, 5'd31, 6'd63, CH_BAD,  1'b1, 1'b1);
    send_req(REQ_POLARITY, 1'b0, 5'd0,  6'd0,  CH_NONE, 1'b0, 1'b1);
    send_req(REQ_MANUAL,   1'b0, 5'd0,  6'd0,  CH_TWO,  1'b1, 1'b0);
    send_req(REQ_TICK,     1'b1, 5'd2,  6'd0,  CH_NONE, 1'b0, 1'b0);
    send_req(REQ_TICK,     1'b1, 5'd2,  6'd0,  CH_BAD,  1'b1, 1'b1);
    send_req(REQ_TICK,     1'b1, 5'd2,  6'd0,  CH_NONE, 1'b0, 1'b0);
    send_req(REQ_MANUAL,   1'b0, 5'd0,  6'd0,  CH_TWO,  1'b1, 1'b0);
    send_req(REQ_TICK,     1'b1, 5'd2,  6'd0,  CH_NONE, 1'b0, 1'b0);
    send_req(REQ_TICK,     1'b1, 5'd1,  6'd0,  CH_NONE, 1'b0, 1'b0);
    send_req(REQ_TICK,     1'b1, 5'd31, 6'd63, CH_NONE, 1'b0, 1'b0);
    send_req(REQ_TICK,     1'b1, 5'd0,  6'd0,  CH_NONE, 1'b0, 1'b0);
    send_req(REQ_TICK,     1'b1, 5'd23, 6'd59, CH_NONE, 1'b0, 1'b0);
    send_req(REQ_TICK,     1'b0, 5'd1,  6'd0,  CH_NONE, 1'b0, 1'b0);
    send_req(REQ_POLARITY, 1'b0, 5'd0,  6'd0,  CH_NONE, 1'b0, 1'b0);
    send_req(REQ_TICK,     1'b1, 5'd3,  6'd0,  CH_NONE, 1'b0, 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      load_table(p);
      random_phase(ItemsPerPhase);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d ticks, %0d manual commands, %0d polarity sets, %0d unused requests",
             n_tick, n_manual, n_pol, n_rsvd);
    $display("over %0d job tables; %0d status beats checked, %0d mismatches",
             NumPhases + 1, got_count, fail_count);
    if (fail_count == 0 && exp_count == got_count) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
